>>> rtl/rsh_pkg.sv
// Shared constants, register codes and beat types for the route selector.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package rsh_pkg;

   localparam int MAX_CANDIDATES = 16;
   localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

   localparam int ROUTE_W  = 16;
   localparam int COST_W   = 32;
   localparam int LEN_W    = 32;
   localparam int FACTOR_W = 16;
   localparam int SLACK_W  = 16;
   localparam int SEL_W    = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Q4.12 factor and Q2.14 slack scaling.
   localparam int HYST_SHIFT  = 12;
   localparam int SLACK_SHIFT = 14;
   localparam int HYST_PROD_W = COST_W + FACTOR_W;
   localparam int SLACK_SUM_W = SLACK_W + 1;
   localparam int LEN_PROD_W  = LEN_W + SLACK_SUM_W;

   localparam logic [SLACK_W-1:0]  SLACK_ONE    = SLACK_W'(16384);
   localparam logic [FACTOR_W-1:0] FACTOR_ONE   = FACTOR_W'(4096);
   localparam logic [LEN_W-1:0]    LEN_INFINITE = '1;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HAS_PREVIOUS      = 3'd0,
      CSR_PREVIOUS_ROUTE    = 3'd1,
      CSR_PREVIOUS_COST     = 3'd2,
      CSR_HOLD_SWITCH       = 3'd3,
      CSR_HYSTERESIS_FACTOR = 3'd4,
      CSR_PREVIOUS_LENGTH   = 3'd5,
      CSR_DETOUR_SLACK      = 3'd6,
      CSR_TRUST_FLOOR       = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                has_previous;
      logic [ROUTE_W-1:0]  previous_route;
      logic [COST_W-1:0]   previous_cost;
      logic                hold_switch;
      logic [FACTOR_W-1:0] hysteresis_factor;
      logic [LEN_W-1:0]    previous_length;
      logic [SLACK_W-1:0]  detour_slack;
      logic [COST_W-1:0]   trust_floor;
   } cfg_type;

   // One classified candidate on its way from the front to the back.
   typedef struct packed {
      logic              last;
      logic              fb_upd;        // feasible member of the previous route
      logic              off_upd;       // enters the ranking under the rules
      logic              open_upd;      // enters the ranking without the rules
      logic              offered_rule;  // previous exists and its anchor is trusted
      logic              has_previous;
      logic [COST_W-1:0] cost;
      logic [IDX_W-1:0]  idx;
   } beat_type;

endpackage

>>> rtl/rsh_if.sv
// Valid/ready channel interfaces for candidate beats and result beats.
// Depends on rsh_pkg for field widths.
`timescale 1ns / 1ps

interface rsh_req_if;
   logic                         valid;
   logic                         ready;
   logic                         feasible;
   logic [rsh_pkg::ROUTE_W-1:0]  route_tag;
   logic [rsh_pkg::COST_W-1:0]   candidate_cost;
   logic [rsh_pkg::LEN_W-1:0]    path_len;
   logic                         last_item;

   modport source (
      output valid, feasible, route_tag, candidate_cost, path_len, last_item,
      input  ready
   );
   modport sink (
      input  valid, feasible, route_tag, candidate_cost, path_len, last_item,
      output ready
   );
endinterface

interface rsh_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [rsh_pkg::SEL_W-1:0]  selected_index;

   modport source (
      output valid, found, selected_index,
      input  ready
   );
   modport sink (
      input  valid, found, selected_index,
      output ready
   );
endinterface

>>> rtl/rsh_front.sv
// Front end: accepts candidate beats, numbers them and classifies each one
// against the continuity rules. Depends on rsh_pkg and rsh_req_if.
`timescale 1ns / 1ps

module rsh_front (
   input  logic               clock,
   input  logic               reset,
   input  rsh_pkg::cfg_type   cfg,
   rsh_req_if.sink            req_ch,
   output logic               out_valid,
   input  logic               out_ready,
   output rsh_pkg::beat_type  out_beat
);
   import rsh_pkg::*;

   typedef struct packed {
      logic                   usable;
      logic                   same;
      logic                   trusted;
      logic                   has_previous;
      logic                   hold_switch;
      logic                   guard_on;
      logic                   last;
      logic [COST_W-1:0]      cost;
      logic [LEN_W-1:0]       len;
      logic [IDX_W-1:0]       idx;
      logic [HYST_PROD_W-1:0] hyst_prod;
      logic [LEN_PROD_W-1:0]  len_limit;
   } stage_type;

   logic                   s1_valid_ff, s1_valid_in;
   stage_type              stage_ff, stage_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   advance, req_fire, in_range;
   logic [SLACK_SUM_W-1:0] slack_sum;
   logic [HYST_PROD_W-1:0] cost_scaled;
   logic [LEN_PROD_W-1:0]  len_scaled;
   logic                   rules_ok;

   assign advance      = !s1_valid_ff || out_ready;
   assign req_ch.ready = advance;
   assign req_fire     = req_ch.valid && advance;
   assign in_range     = count_ff < CNT_W'(MAX_CANDIDATES);
   assign slack_sum    = {1'b0, cfg.detour_slack} + SLACK_SUM_W'(SLACK_ONE);

   always_comb begin
      stage_in.usable       = req_ch.feasible && in_range;
      stage_in.same         = cfg.has_previous && (req_ch.route_tag == cfg.previous_route);
      stage_in.trusted      = !cfg.has_previous || (cfg.previous_cost >= cfg.trust_floor);
      stage_in.has_previous = cfg.has_previous;
      stage_in.hold_switch  = cfg.hold_switch;
      stage_in.guard_on     = (cfg.detour_slack < SLACK_ONE) &&
                              (cfg.previous_length != LEN_INFINITE);
      stage_in.last         = req_ch.last_item;
      stage_in.cost         = req_ch.candidate_cost;
      stage_in.len          = req_ch.path_len;
      stage_in.idx          = count_ff[IDX_W-1:0];
      stage_in.hyst_prod    = HYST_PROD_W'(cfg.previous_cost) *
                              HYST_PROD_W'(cfg.hysteresis_factor);
      stage_in.len_limit    = LEN_PROD_W'(cfg.previous_length) * LEN_PROD_W'(slack_sum);
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         if (req_ch.last_item) begin
            count_in = '0;
         end else if (in_range) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
      end
      if (req_fire) begin
         stage_ff <= stage_in;
      end
   end

   // Classification of the staged candidate.
   assign cost_scaled = {{(HYST_PROD_W - COST_W - HYST_SHIFT){1'b0}},
                         stage_ff.cost, {HYST_SHIFT{1'b0}}};
   assign len_scaled  = {{(LEN_PROD_W - LEN_W - SLACK_SHIFT){1'b0}},
                         stage_ff.len, {SLACK_SHIFT{1'b0}}};
   assign rules_ok    = !stage_ff.hold_switch &&
                        (cost_scaled < stage_ff.hyst_prod) &&
                        !(stage_ff.guard_on && (len_scaled > stage_ff.len_limit));

   always_comb begin
      out_beat.last         = stage_ff.last;
      out_beat.fb_upd       = stage_ff.usable && stage_ff.same;
      out_beat.off_upd      = stage_ff.usable &&
                              (stage_ff.same ? stage_ff.trusted
                                             : (!stage_ff.has_previous || rules_ok));
      out_beat.open_upd     = stage_ff.usable && (!stage_ff.same || stage_ff.trusted);
      out_beat.offered_rule = stage_ff.has_previous && stage_ff.trusted;
      out_beat.has_previous = stage_ff.has_previous;
      out_beat.cost         = stage_ff.cost;
      out_beat.idx          = stage_ff.idx;
   end

   assign out_valid = s1_valid_ff;

endmodule

>>> rtl/rsh_fifo.sv
// Short queue of classified beats between the front end and the back end.
// Depends on rsh_pkg for the beat type and depth.
`timescale 1ns / 1ps

module rsh_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rsh_pkg::beat_type  in_beat,
   output logic               out_valid,
   input  logic               out_ready,
   output rsh_pkg::beat_type  out_beat
);
   import rsh_pkg::*;

   beat_type             mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   fill_ff, fill_in;
   logic                 push, pop;

   assign in_ready  = fill_ff != FIFO_CW'(FIFO_DEPTH);
   assign out_valid = fill_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_beat  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_AW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_beat;
      end
   end

endmodule

>>> rtl/rsh_back.sv
// Back end: three running minimum trackers and the end-of-batch decision,
// with a registered result beat. Depends on rsh_pkg and rsh_rsp_if.
`timescale 1ns / 1ps

module rsh_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rsh_pkg::beat_type  in_beat,
   rsh_rsp_if.source          rsp_ch
);
   import rsh_pkg::*;

   logic              prev_present_ff, prev_present_in;
   logic              off_valid_ff, off_valid_in, open_valid_ff, open_valid_in;
   logic              fb_valid_ff, fb_valid_in;
   logic [COST_W-1:0] off_cost_ff, off_cost_in, open_cost_ff, open_cost_in;
   logic [COST_W-1:0] fb_cost_ff, fb_cost_in;
   logic [IDX_W-1:0]  off_idx_ff, off_idx_in, open_idx_ff, open_idx_in;
   logic [IDX_W-1:0]  fb_idx_ff, fb_idx_in;
   logic              off_take, open_take, fb_take, pop, offered;
   logic              pick_valid, found_in, found_ff, rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  pick_idx, sel_idx;
   logic [SEL_W-1:0]  sel_in, sel_ff;

   assign in_ready = !in_beat.last || !rsp_valid_ff || rsp_ch.ready;
   assign pop      = in_valid && in_ready;

   // A strictly lower cost replaces the held one, so earlier candidates win ties.
   assign off_take  = in_beat.off_upd  && (!off_valid_ff  || in_beat.cost < off_cost_ff);
   assign open_take = in_beat.open_upd && (!open_valid_ff || in_beat.cost < open_cost_ff);
   assign fb_take   = in_beat.fb_upd   && (!fb_valid_ff   || in_beat.cost < fb_cost_ff);

   assign off_valid_in    = off_valid_ff  || off_take;
   assign open_valid_in   = open_valid_ff || open_take;
   assign fb_valid_in     = fb_valid_ff   || fb_take;
   assign off_cost_in     = off_take  ? in_beat.cost : off_cost_ff;
   assign open_cost_in    = open_take ? in_beat.cost : open_cost_ff;
   assign fb_cost_in      = fb_take   ? in_beat.cost : fb_cost_ff;
   assign off_idx_in      = off_take  ? in_beat.idx  : off_idx_ff;
   assign open_idx_in     = open_take ? in_beat.idx  : open_idx_ff;
   assign fb_idx_in       = fb_take   ? in_beat.idx  : fb_idx_ff;
   assign prev_present_in = prev_present_ff || in_beat.fb_upd;

   always_comb begin
      offered    = in_beat.offered_rule && prev_present_in;
      pick_valid = offered ? off_valid_in : open_valid_in;
      pick_idx   = offered ? off_idx_in   : open_idx_in;
      found_in   = pick_valid;
      sel_idx    = pick_idx;
      if (!pick_valid && in_beat.has_previous && prev_present_in && fb_valid_in) begin
         found_in = 1'b1;
         sel_idx  = fb_idx_in;
      end
      sel_in = found_in ? SEL_W'(sel_idx) : '0;
   end

   assign rsp_valid_in = (pop && in_beat.last) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_present_ff <= 1'b0;
         off_valid_ff    <= 1'b0;
         open_valid_ff   <= 1'b0;
         fb_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (in_beat.last) begin
               prev_present_ff <= 1'b0;
               off_valid_ff    <= 1'b0;
               open_valid_ff   <= 1'b0;
               fb_valid_ff     <= 1'b0;
            end else begin
               prev_present_ff <= prev_present_in;
               off_valid_ff    <= off_valid_in;
               open_valid_ff   <= open_valid_in;
               fb_valid_ff     <= fb_valid_in;
            end
         end
      end
      if (pop) begin
         off_cost_ff  <= off_cost_in;
         open_cost_ff <= open_cost_in;
         fb_cost_ff   <= fb_cost_in;
         off_idx_ff   <= off_idx_in;
         open_idx_ff  <= open_idx_in;
         fb_idx_ff    <= fb_idx_in;
      end
      if (pop && in_beat.last) begin
         found_ff <= found_in;
         sel_ff   <= sel_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = found_ff;
   assign rsp_ch.selected_index = sel_ff;

endmodule

>>> rtl/route_select_with_hysteresis_top.sv
// Top level of the route selector: configuration registers, front end,
// beat queue and back end. Depends on rsh_pkg, rsh_if, rsh_front, rsh_fifo, rsh_back.
`timescale 1ns / 1ps

// The block takes one candidate beat per clock cycle on req_ch, unless stalled,
// and for the beat marked last_item returns one result beat on rsp_ch that tells
// whether a candidate was selected and its position in the batch (zero when none).
// Candidates past the sixteenth of a batch are ignored, but the batch still ends
// at its last_item beat. The sustained rate is one candidate per cycle while
// nothing stalls: the front end does both threshold multiplies of a candidate in
// its one register stage and the back end updates all three minimum trackers per
// beat. The last candidate passes the front-end register and the queue, and the
// result beat is registered in the back end. A two-entry queue sits between front
// and back, so candidates keep flowing while a finished result waits on rsp_ch.
// Configuration is written through csr_we, csr_idx and csr_wdata; each
// candidate is judged with the register values present when it is accepted,
// and writes are meant to happen only while no batch is in flight.

module route_select_with_hysteresis_top (
   input  logic                             clock,
   input  logic                             reset,
   rsh_req_if.sink                          req_ch,
   rsh_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [rsh_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [rsh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rsh_pkg::*;

   localparam cfg_type CFG_RESET = '{
      has_previous:      1'b0,
      previous_route:    '0,
      previous_cost:     '0,
      hold_switch:       1'b0,
      hysteresis_factor: FACTOR_ONE,
      previous_length:   LEN_INFINITE,
      detour_slack:      '1,
      trust_floor:       '0
   };

   cfg_type  cfg_ff, cfg_in;
   logic     fr_valid, fr_ready, bk_valid, bk_ready;
   beat_type fr_beat, bk_beat;

   // Register writes: each index owns one field, wider data is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_HAS_PREVIOUS:      cfg_in.has_previous      = csr_wdata[0];
            CSR_PREVIOUS_ROUTE:    cfg_in.previous_route    = csr_wdata[ROUTE_W-1:0];
            CSR_PREVIOUS_COST:     cfg_in.previous_cost     = csr_wdata[COST_W-1:0];
            CSR_HOLD_SWITCH:       cfg_in.hold_switch       = csr_wdata[0];
            CSR_HYSTERESIS_FACTOR: cfg_in.hysteresis_factor = csr_wdata[FACTOR_W-1:0];
            CSR_PREVIOUS_LENGTH:   cfg_in.previous_length   = csr_wdata[LEN_W-1:0];
            CSR_DETOUR_SLACK:      cfg_in.detour_slack      = csr_wdata[SLACK_W-1:0];
            CSR_TRUST_FLOOR:       cfg_in.trust_floor       = csr_wdata[COST_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end numbers and classifies candidates.
   rsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_beat  (fr_beat)
   );

   // The queue lets the front keep accepting while the back waits on a result.
   rsh_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_beat   (fr_beat),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_beat  (bk_beat)
   );

   // The back end runs the trackers and forms the result beat.
   rsh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bk_valid),
      .in_ready (bk_ready),
      .in_beat  (bk_beat),
      .rsp_ch   (rsp_ch)
   );

   // A result only appears right after the back end consumed a last beat.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(bk_valid && bk_ready && bk_beat.last))
      else $error("result beat appeared without a last beat");

   // Every last beat consumed by the back end yields a result the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (bk_valid && bk_ready && bk_beat.last) |=> rsp_ch.valid)
      else $error("last beat consumed without a result beat");

   // A trusted previous-route member must enter both rankings.
   a_trusted_member: assert property (@(posedge clock) disable iff (reset)
      (fr_valid && fr_beat.fb_upd && fr_beat.offered_rule)
         |-> (fr_beat.off_upd && fr_beat.open_upd))
      else $error("trusted previous-route member missed a ranking");

   // With nothing selected the index field reads zero.
   a_none_zero_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> (rsp_ch.selected_index == '0))
      else $error("empty result carries a nonzero index");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the route selector with hysteresis: a driver, a monitor and a
// scoring model of the candidate ranking. Depends on rsh_pkg, rsh_if and the top level.
`timescale 1ns / 1ps

module testbench;
   import rsh_pkg::*;

   // Cycles that may pass without any beat on either channel before the run is
   // declared hung. The longest legal quiet stretch is the deliberate receiver
   // hold plus a couple of random waits.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 6;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;

   typedef struct {
      logic                feasible;
      logic [ROUTE_W-1:0]  route_tag;
      logic [COST_W-1:0]   candidate_cost;
      logic [LEN_W-1:0]    path_len;
      logic                last_item;
   } cand_type;

   typedef struct {
      logic             found;
      logic [SEL_W-1:0] selected_index;
   } pick_type;

   // One running minimum; the valid bit lets an all-ones cost still win.
   typedef struct {
      bit                valid;
      logic [COST_W-1:0] cost;
      int unsigned       index;
   } min_track_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rsh_req_if req_ch ();
   rsh_rsp_if rsp_ch ();

   route_select_with_hysteresis_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Scoring model state: its own copy of the registers and of the batch trackers.
   cfg_type       model_cfg;
   int unsigned   batch_pos;
   bit            prev_seen;
   min_track_type ruled_min;     // ranking with the continuity rules applied
   min_track_type free_min;      // ranking with no rules
   min_track_type fallback_min;  // feasible members of the previous route

   cand_type candidate_q[$];      // beats waiting for the driver
   pick_type expected_picks[$];   // selections predicted but not yet returned

   cand_type    offer_cand;
   bit          offering;
   bit          sender_burst;
   int unsigned sender_wait;
   bit          receiver_burst;
   int unsigned receiver_wait;
   int unsigned hold_left;
   int unsigned hold_requests;
   int unsigned holds_done;
   int unsigned results_seen;
   int unsigned fail_count;
   int unsigned quiet_cycles;

   // Per-phase pools used to make routes collide and costs tie.
   logic [ROUTE_W-1:0] alt_routes[3];
   logic [COST_W-1:0]  tie_costs[4];

   function automatic int unsigned draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic logic [31:0] sat32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic min_track_type track_min(min_track_type t, logic [COST_W-1:0] cost,
                                               int unsigned index);
      // Strictly lower wins, so the earlier candidate keeps a tie.
      if (!t.valid || cost < t.cost) begin
         t.valid = 1'b1;
         t.cost  = cost;
         t.index = index;
      end
      return t;
   endfunction

   function automatic void clear_batch();
      batch_pos    = 0;
      prev_seen    = 1'b0;
      ruled_min    = '{valid: 1'b0, cost: '1, index: 0};
      free_min     = '{valid: 1'b0, cost: '1, index: 0};
      fallback_min = '{valid: 1'b0, cost: '1, index: 0};
   endfunction

   // A previous route below the anchor floor is not trusted.
   function automatic bit anchor_ok();
      return !model_cfg.has_previous || (model_cfg.previous_cost >= model_cfg.trust_floor);
   endfunction

   // Switch blocking, hysteresis margin and progress guard for a candidate
   // that would leave the previous route.
   function automatic bit clears_rules(logic [COST_W-1:0] cost, logic [LEN_W-1:0] len);
      logic [63:0] lhs;
      logic [63:0] rhs;
      if (model_cfg.hold_switch)
         return 1'b0;
      lhs = 64'(cost) << HYST_SHIFT;
      rhs = 64'(model_cfg.previous_cost) * 64'(model_cfg.hysteresis_factor);
      if (lhs >= rhs)
         return 1'b0;
      if (model_cfg.detour_slack < SLACK_ONE && model_cfg.previous_length != LEN_INFINITE) begin
         lhs = 64'(len) << SLACK_SHIFT;
         rhs = 64'(model_cfg.previous_length) *
               (64'(SLACK_ONE) + 64'(model_cfg.detour_slack));
         if (lhs > rhs)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Folds one accepted candidate into the trackers; on the last beat of a
   // batch it queues the predicted selection and starts a fresh batch.
   function automatic void rank_candidate(cand_type c);
      int unsigned   idx;
      bit            same;
      bit            offered;
      min_track_type chosen;
      pick_type      pick;
      if (batch_pos < MAX_CANDIDATES) begin
         idx = batch_pos;
         batch_pos++;
         if (c.feasible) begin
            same = model_cfg.has_previous && (c.route_tag == model_cfg.previous_route);
            if (same) begin
               prev_seen    = 1'b1;
               fallback_min = track_min(fallback_min, c.candidate_cost, idx);
               if (anchor_ok()) begin
                  ruled_min = track_min(ruled_min, c.candidate_cost, idx);
                  free_min  = track_min(free_min, c.candidate_cost, idx);
               end
            end else begin
               free_min = track_min(free_min, c.candidate_cost, idx);
               if (!model_cfg.has_previous || clears_rules(c.candidate_cost, c.path_len))
                  ruled_min = track_min(ruled_min, c.candidate_cost, idx);
            end
         end
      end
      if (c.last_item) begin
         offered = model_cfg.has_previous && prev_seen && anchor_ok();
         chosen  = offered ? ruled_min : free_min;
         if (!chosen.valid && model_cfg.has_previous && prev_seen && fallback_min.valid)
            chosen = fallback_min;
         pick.found          = chosen.valid;
         pick.selected_index = chosen.valid ? SEL_W'(chosen.index) : '0;
         expected_picks.insert(expected_picks.size(), pick);
         clear_batch();
      end
   endfunction

   // Driver: one beat at a time from candidate_q, with a drawn wait before
   // each. The handshake is judged on the values present at the edge, and the
   // model is updated in the same step the beat is taken.
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_ch.valid;
      if (reset) begin
         next_valid = 1'b0;
         offering   = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            rank_candidate(offer_cand);
            next_valid  = 1'b0;
            offering    = 1'b0;
            sender_wait = draw_wait(sender_burst);
         end
         if (!next_valid) begin
            if (sender_wait == 0 && candidate_q.size() != 0) begin
               offer_cand = candidate_q.pop_front();
               req_ch.feasible       <= offer_cand.feasible;
               req_ch.route_tag      <= offer_cand.route_tag;
               req_ch.candidate_cost <= offer_cand.candidate_cost;
               req_ch.path_len       <= offer_cand.path_len;
               req_ch.last_item      <= offer_cand.last_item;
               next_valid = 1'b1;
               offering   = 1'b1;
            end else if (sender_wait > 0) begin
               sender_wait--;
            end
         end
      end
      req_ch.valid <= next_valid;
   end

   // Monitor: compares each result beat with the oldest prediction. Ready is
   // dropped for a drawn number of cycles after each beat, and for a long
   // hold whenever the stimulus asks for one, so the block backs up.
   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_picks.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat: expected none, %s found=%0b index=%0d",
                        $time, "actual", rsp_ch.found, rsp_ch.selected_index);
            end else begin
               want = expected_picks.pop_front();
               if (rsp_ch.found !== want.found ||
                   rsp_ch.selected_index !== want.selected_index) begin
                  fail_count++;
                  $display("%0t: selection mismatch: expected found=%0b index=%0d,",
                           $time, want.found, want.selected_index);
                  $display("%0t:    actual found=%0b index=%0d",
                           $time, rsp_ch.found, rsp_ch.selected_index);
               end
            end
            results_seen++;
            if (results_seen % 64 == 0)
               receiver_burst = ($urandom_range(0, 3) == 0);
            receiver_wait = draw_wait(receiver_burst);
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0)
            hold_left--;
         else if (receiver_wait > 0)
            receiver_wait--;
         rsp_ch.ready <= (hold_left == 0 && receiver_wait == 0);
      end
   end

   // Watchdog: any beat on either channel counts as progress.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Blocks until every queued beat is taken and every selection has come
   // back, then lets the pipeline drain before anything else happens.
   task automatic wait_idle();
      while (candidate_q.size() != 0 || offering || expected_picks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the model copy is updated at the same time, which is
   // safe because writes only happen while the block is idle.
   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HAS_PREVIOUS:      model_cfg.has_previous      = value[0];
         CSR_PREVIOUS_ROUTE:    model_cfg.previous_route    = value[ROUTE_W-1:0];
         CSR_PREVIOUS_COST:     model_cfg.previous_cost     = value[COST_W-1:0];
         CSR_HOLD_SWITCH:       model_cfg.hold_switch       = value[0];
         CSR_HYSTERESIS_FACTOR: model_cfg.hysteresis_factor = value[FACTOR_W-1:0];
         CSR_PREVIOUS_LENGTH:   model_cfg.previous_length   = value[LEN_W-1:0];
         CSR_DETOUR_SLACK:      model_cfg.detour_slack      = value[SLACK_W-1:0];
         CSR_TRUST_FLOOR:       model_cfg.trust_floor       = value[COST_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_settings(cfg_type s);
      write_reg(CSR_HAS_PREVIOUS,      32'(s.has_previous));
      write_reg(CSR_PREVIOUS_ROUTE,    32'(s.previous_route));
      write_reg(CSR_PREVIOUS_COST,     32'(s.previous_cost));
      write_reg(CSR_HOLD_SWITCH,       32'(s.hold_switch));
      write_reg(CSR_HYSTERESIS_FACTOR, 32'(s.hysteresis_factor));
      write_reg(CSR_PREVIOUS_LENGTH,   32'(s.previous_length));
      write_reg(CSR_DETOUR_SLACK,      32'(s.detour_slack));
      write_reg(CSR_TRUST_FLOOR,       32'(s.trust_floor));
   endtask

   function automatic void push_cand(logic f, logic [ROUTE_W-1:0] r, logic [COST_W-1:0] c,
                                     logic [LEN_W-1:0] l, logic last);
      cand_type b;
      b = '{feasible: f, route_tag: r, candidate_cost: c, path_len: l, last_item: last};
      candidate_q.insert(candidate_q.size(), b);
   endfunction

   // Register settings biased toward the edges of each field and toward the
   // points where the anchor floor and the progress guard change behavior.
   function automatic cfg_type random_settings();
      cfg_type s;
      s.has_previous = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 3))
         0:       s.previous_route = '0;
         1:       s.previous_route = '1;
         2:       s.previous_route = 16'($urandom_range(0, 7));
         default: s.previous_route = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0:       s.previous_cost = '0;
         1:       s.previous_cost = '1;
         2:       s.previous_cost = $urandom_range(1, 1000) << 16;
         default: s.previous_cost = $urandom();
      endcase
      s.hold_switch = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 4))
         0:       s.hysteresis_factor = '0;
         1:       s.hysteresis_factor = FACTOR_ONE;
         2:       s.hysteresis_factor = '1;
         3:       s.hysteresis_factor = 16'($urandom_range(4096, 8192));
         default: s.hysteresis_factor = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0:       s.previous_length = '0;
         1:       s.previous_length = LEN_INFINITE;
         2:       s.previous_length = $urandom_range(1, 2000) << 16;
         default: s.previous_length = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0:       s.detour_slack = '0;
         1:       s.detour_slack = SLACK_ONE - 16'd1;
         2:       s.detour_slack = SLACK_ONE;
         3:       s.detour_slack = '1;
         default: s.detour_slack = 16'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 4))
         0:       s.trust_floor = '0;
         1:       s.trust_floor = '1;
         2:       s.trust_floor = s.previous_cost;
         3:       s.trust_floor = s.previous_cost + 32'd1;
         default: s.trust_floor = $urandom();
      endcase
      return s;
   endfunction

   // Builds a candidate around the current registers: many on the previous
   // route, costs and lengths on either side of the hysteresis and progress
   // thresholds, and repeated costs so that ties occur.
   function automatic cand_type make_cand(bit last);
      cand_type    c;
      logic [31:0] hyst_edge;
      logic [31:0] len_edge;
      hyst_edge = sat32((64'(model_cfg.previous_cost) * 64'(model_cfg.hysteresis_factor))
                        >> HYST_SHIFT);
      len_edge  = sat32((64'(model_cfg.previous_length) *
                        (64'(SLACK_ONE) + 64'(model_cfg.detour_slack))) >> SLACK_SHIFT);
      c.feasible  = ($urandom_range(0, 6) != 0);
      c.last_item = last;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c.route_tag = model_cfg.previous_route;
         4, 5, 6:    c.route_tag = alt_routes[$urandom_range(0, 2)];
         7:          c.route_tag = 16'($urandom());
         8:          c.route_tag = model_cfg.previous_route ^ 16'h0001;
         default:    c.route_tag = $urandom_range(0, 1) ? '0 : '1;
      endcase
      case ($urandom_range(0, 7))
         0:       c.candidate_cost = hyst_edge - 1;
         1:       c.candidate_cost = hyst_edge;
         2:       c.candidate_cost = hyst_edge + 1;
         3:       c.candidate_cost = $urandom();
         4:       c.candidate_cost = tie_costs[$urandom_range(0, 3)];
         5:       c.candidate_cost = $urandom_range(0, 1) ? '0 : '1;
         6:       c.candidate_cost = model_cfg.previous_cost;
         default: c.candidate_cost = $urandom_range(0, hyst_edge);
      endcase
      case ($urandom_range(0, 5))
         0:       c.path_len = len_edge - 1;
         1:       c.path_len = len_edge;
         2:       c.path_len = len_edge + 1;
         3:       c.path_len = $urandom();
         4:       c.path_len = $urandom_range(0, 1) ? '0 : '1;
         default: c.path_len = $urandom_range(0, len_edge);
      endcase
      return c;
   endfunction

   initial begin
      cfg_type     phase_cfg;
      int unsigned phase_items;
      int unsigned batch_len;
      bit          hold_phase;

      // Every input is known from time zero; the model starts in its reset state.
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_idx               = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.feasible       = 1'b0;
      req_ch.route_tag      = '0;
      req_ch.candidate_cost = '0;
      req_ch.path_len       = '0;
      req_ch.last_item      = 1'b0;
      rsp_ch.ready          = 1'b0;
      offering       = 1'b0;
      sender_burst   = 1'b0;
      sender_wait    = 0;
      receiver_burst = 1'b0;
      receiver_wait  = 0;
      hold_left      = 0;
      hold_requests  = 0;
      holds_done     = 0;
      results_seen   = 0;
      fail_count     = 0;
      quiet_cycles   = 0;
      model_cfg = '{has_previous: 1'b0, previous_route: '0, previous_cost: '0,
                    hold_switch: 1'b0, hysteresis_factor: FACTOR_ONE,
                    previous_length: LEN_INFINITE, detour_slack: '1, trust_floor: '0};
      clear_batch();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first on the reset values of the registers with no
      // previous route. An all-ones cost must still be selectable.
      push_cand(1'b1, 16'h0000, '1, '0, 1'b1);
      // Infeasible leader, a tie between two equal costs, extreme fields last.
      push_cand(1'b0, 16'hFFFF, '0, '1, 1'b0);
      push_cand(1'b1, 16'h1234, 32'd5, '0, 1'b0);
      push_cand(1'b1, 16'h4321, 32'd5, '1, 1'b0);
      push_cand(1'b1, 16'hFFFF, '1, '1, 1'b1);
      // A batch with nothing feasible reports no selection.
      push_cand(1'b0, 16'h0000, '0, '0, 1'b1);
      // An overlong batch: the seventeenth candidate is the cheapest but is
      // past the limit, so the sixteenth must win.
      for (int i = 0; i < 17; i++)
         push_cand(1'b1, 16'(i), (i < 16) ? 32'(1000 - i) : 32'd0, 32'(i), i == 16);
      wait_idle();

      // Previous route 7 offered and trusted: margin 1.5, ten percent detour.
      // Candidate 1 beats the margin and guard; candidate 2 is cheaper but
      // takes too long a path.
      phase_cfg = '{has_previous: 1'b1, previous_route: 16'd7, previous_cost: 32'd100 << 16,
                    hold_switch: 1'b0, hysteresis_factor: 16'h1800,
                    previous_length: 32'd1000 << 16, detour_slack: 16'd1638,
                    trust_floor: '0};
      program_settings(phase_cfg);
      push_cand(1'b1, 16'd7, 32'd90 << 16, '0, 1'b0);
      push_cand(1'b1, 16'd3, 32'd80 << 16, 32'd1000 << 16, 1'b0);
      push_cand(1'b1, 16'd4, 32'd10 << 16, 32'd2000 << 16, 1'b0);
      push_cand(1'b0, 16'd5, '0, '0, 1'b1);
      wait_idle();

      // Anchor below the floor: the previous route is left out of the ranking
      // and switch blocking has no effect; alone, it is taken as the fallback.
      phase_cfg.hold_switch = 1'b1;
      phase_cfg.trust_floor = 32'd200 << 16;
      program_settings(phase_cfg);
      push_cand(1'b1, 16'd7, 32'd5, '0, 1'b0);
      push_cand(1'b1, 16'd2, 32'd60 << 16, '0, 1'b1);
      push_cand(1'b1, 16'd7, 32'd5, '0, 1'b1);
      wait_idle();

      // Random phases. Each gets fresh settings, written while idle; two of
      // them run the sender flat out while the receiver holds off, so the
      // block fills up and stalls its input.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         hold_phase = (phase == 3 || phase == 8);
         phase_cfg  = random_settings();
         if (phase == 1) begin
            phase_cfg = '1;
         end else if (phase == 2) begin
            phase_cfg = '0;
            phase_cfg.has_previous = 1'b1;
         end
         program_settings(phase_cfg);
         for (int i = 0; i < 3; i++)
            alt_routes[i] = ($urandom_range(0, 1) != 0) ? 16'(model_cfg.previous_route + i + 1)
                                                      : 16'($urandom());
         for (int i = 0; i < 4; i++)
            tie_costs[i] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 64) : $urandom();
         sender_burst = hold_phase ? 1'b1 : ($urandom_range(0, 3) == 0);
         phase_items  = 0;
         while (phase_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       batch_len = $urandom_range(17, 20);
               1, 2:    batch_len = $urandom_range(7, 16);
               default: batch_len = $urandom_range(1, 6);
            endcase
            for (int unsigned k = 0; k < batch_len; k++)
               candidate_q.insert(candidate_q.size(), make_cand(k == batch_len - 1));
            phase_items += batch_len;
         end
         if (hold_phase)
            hold_requests++;
         // The sender waits here until every selection of the phase is back.
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/rsh_pkg.sv
rtl/rsh_if.sv
rtl/rsh_front.sv
rtl/rsh_fifo.sv
rtl/rsh_back.sv
rtl/route_select_with_hysteresis_top.sv
bench/testbench.sv
